>>> rtl/i2cbb_pkg.sv
// ---------------------------------------------------------------------------
// i2cbb_pkg
// shared opcodes, slot counts and the result record of the i2c bit engine
// ---------------------------------------------------------------------------
package i2cbb_pkg;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_ACK    = 3'd4;
  localparam logic [2:0] OP_NACK   = 3'd5;
  localparam logic [2:0] OP_SAMPLE = 3'd6;

  localparam logic [2:0] SLOTS_START_STOP = 3'd6;
  localparam logic [2:0] SLOTS_ACK        = 3'd5;
  localparam logic [2:0] SLOTS_BIT        = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] MSB_MASK      = 8'h80;

  localparam logic [15:0] HALF_DELAY_RESET = 16'd50;
  localparam int          CFG_DATA_W       = 32;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       ack_seen;
  } result_t;

  function automatic logic [2:0] slot_count(input logic [2:0] op);
    logic [2:0] n;
    begin
      n = SLOTS_BIT;
      if (op == OP_START || op == OP_STOP) n = SLOTS_START_STOP;
      else if (op == OP_ACK) n = SLOTS_ACK;
      return n;
    end
  endfunction

endpackage

>>> rtl/i2cbb_engine.sv
// ---------------------------------------------------------------------------
// i2cbb_engine
// bus engine state and its one-tick update; advances once per transaction
// ---------------------------------------------------------------------------
module i2cbb_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                cmd_valid,
  input  logic [2:0]          opcode,
  input  logic [7:0]          write_byte,
  input  logic                sda_in,
  input  logic [15:0]         half_delay_ticks,
  output i2cbb_pkg::result_t  res_next
);

  logic [2:0]  current_op, current_op_next;
  logic [2:0]  phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        sda_mode, sda_mode_next;
  logic        busy, busy_next;
  logic [7:0]  read_hold, read_hold_next;
  logic        ack_hold, ack_hold_next;
  logic        done;
  logic [15:0] half;
  logic        slot_end;

  assign half = (half_delay_ticks == 16'd0) ? 16'd1 : half_delay_ticks;

  always_comb begin
    current_op_next = current_op;
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_mode_next   = sda_mode;
    busy_next       = busy;
    read_hold_next  = read_hold;
    ack_hold_next   = ack_hold;
    done            = 1'b0;

    // opcode seven starts nothing
    if (!busy && cmd_valid && opcode != 3'd7) begin
      busy_next       = 1'b1;
      current_op_next = opcode;
      phase_next      = 3'd0;
      tick_count_next = 16'd0;
      bit_index_next  = 4'd0;
      shift_reg_next  = (opcode == i2cbb_pkg::OP_WRITE) ? write_byte : 8'd0;
    end

    // last tick of the slot, judged on the count this tick starts from
    slot_end = ({1'b0, tick_count_next} + 17'd1) >= {1'b0, half};

    if (busy_next) begin
      // line changes on the first tick of a slot
      if (tick_count_next == 16'd0) begin
        case (current_op_next)
          i2cbb_pkg::OP_START: begin
            if (phase_next == 3'd0) begin
              sda_mode_next = 1'b1;
              sda_reg_next  = 1'b1;
            end else if (phase_next == 3'd2) scl_reg_next = 1'b1;
            else if (phase_next == 3'd4) sda_reg_next = 1'b0;
            else if (phase_next == 3'd5) scl_reg_next = 1'b0;
          end
          i2cbb_pkg::OP_STOP: begin
            if (phase_next == 3'd0) begin
              sda_mode_next = 1'b1;
              sda_reg_next  = 1'b0;
            end else if (phase_next == 3'd2) scl_reg_next = 1'b1;
            else if (phase_next == 3'd4) sda_reg_next = 1'b1;
          end
          default: begin
            if (phase_next == 3'd0) begin
              if (current_op_next == i2cbb_pkg::OP_WRITE) begin
                sda_mode_next = 1'b1;
                sda_reg_next  = |(shift_reg_next & i2cbb_pkg::MSB_MASK);
              end else if (current_op_next == i2cbb_pkg::OP_ACK) begin
                sda_mode_next = 1'b1;
                sda_reg_next  = 1'b0;
              end else if (current_op_next == i2cbb_pkg::OP_NACK) begin
                sda_mode_next = 1'b1;
                sda_reg_next  = 1'b1;
              end else begin
                sda_mode_next = 1'b0;
                sda_reg_next  = 1'b1;
              end
            end else if (phase_next == 3'd1) scl_reg_next = 1'b1;
            else if (phase_next == 3'd3) scl_reg_next = 1'b0;
          end
        endcase
      end

      if (slot_end) begin
        // sda sampled on the last tick of slot 2 while scl is high
        if (phase_next == 3'd2) begin
          if (current_op_next == i2cbb_pkg::OP_READ)
            shift_reg_next = {shift_reg_next[6:0], sda_in};
          else if (current_op_next == i2cbb_pkg::OP_SAMPLE)
            ack_hold_next = ~sda_in;
        end
        tick_count_next = 16'd0;
        phase_next      = phase_next + 3'd1;
        if (phase_next >= i2cbb_pkg::slot_count(current_op_next)) begin
          phase_next     = 3'd0;
          bit_index_next = bit_index_next + 4'd1;
          if (current_op_next == i2cbb_pkg::OP_WRITE)
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
          if ((current_op_next != i2cbb_pkg::OP_WRITE &&
               current_op_next != i2cbb_pkg::OP_READ) ||
              bit_index_next >= i2cbb_pkg::BITS_PER_BYTE) begin
            if (current_op_next == i2cbb_pkg::OP_READ) read_hold_next = shift_reg_next;
            busy_next      = 1'b0;
            done           = 1'b1;
            bit_index_next = 4'd0;
          end
        end
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end
    end
  end

  always_comb begin
    res_next.scl_level    = scl_reg_next;
    res_next.sda_pull_low = sda_mode_next & ~sda_reg_next;
    res_next.busy         = busy_next;
    res_next.done         = done;
    res_next.read_byte    = read_hold_next;
    res_next.ack_seen     = ack_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_op <= 3'd0;
      phase      <= 3'd0;
      tick_count <= 16'd0;
      bit_index  <= 4'd0;
      shift_reg  <= 8'd0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_mode   <= 1'b1;
      busy       <= 1'b0;
      read_hold  <= 8'd0;
      ack_hold   <= 1'b0;
    end else if (step) begin
      current_op <= current_op_next;
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_mode   <= sda_mode_next;
      busy       <= busy_next;
      read_hold  <= read_hold_next;
      ack_hold   <= ack_hold_next;
    end
  end

endmodule

>>> rtl/i2cbb_skid.sv
// ---------------------------------------------------------------------------
// i2cbb_skid
// result register with one skid entry so input is not blocked by one stall
// ---------------------------------------------------------------------------
module i2cbb_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cbb_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cbb_pkg::result_t out_data
);

  logic               skid_valid;
  i2cbb_pkg::result_t skid_data;
  logic               pop;

  assign pop  = out_valid & ~out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> rtl/i2c_bitbang_master.sv
// ---------------------------------------------------------------------------
// i2c_bitbang_master
// i2c master bit engine, one bus tick per input transaction
// ---------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------------
//  in      | in_valid / in_stall         | cmd_valid opcode write_byte sda_in
//  out     | out_valid / out_stall       | scl_level sda_pull_low busy_res done_res
//          |                             | read_byte ack_seen
//  cfg     | psel penable pwrite pready  | paddr pwdata prdata (half_delay_ticks @0)
//
// every transaction is one tick: accepted in any cycle in which in_stall is low,
// its result registered; one result per transaction
// a skid entry behind the result register absorbs one result while out_stall
// holds the output; in_stall rises only when both entries hold results
// rst is synchronous and returns the lines to released, half delay to 50
// ---------------------------------------------------------------------------
module i2c_bitbang_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic [2:0]  opcode,
  input  logic [7:0]  write_byte,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        ack_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               accept;
  logic [15:0]        half_delay_ticks;
  i2cbb_pkg::result_t res_next;
  i2cbb_pkg::result_t res;
  logic               full;

  assign pready   = 1'b1;
  assign in_stall = full;
  assign accept   = in_valid & ~full;

  // register 0 sits at bytes 0..3; anything above is not decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      half_delay_ticks <= i2cbb_pkg::HALF_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      half_delay_ticks <= pwdata[15:0];
    end
  end

  assign prdata = paddr[2] ? '0 : {{(i2cbb_pkg::CFG_DATA_W-16){1'b0}}, half_delay_ticks};

  i2cbb_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .cmd_valid        (cmd_valid),
    .opcode           (opcode),
    .write_byte       (write_byte),
    .sda_in           (sda_in),
    .half_delay_ticks (half_delay_ticks),
    .res_next         (res_next)
  );

  i2cbb_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_next),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res)
  );

  assign scl_level    = res.scl_level;
  assign sda_pull_low = res.sda_pull_low;
  assign busy_res     = res.busy;
  assign done_res     = res.done;
  assign read_byte    = res.read_byte;
  assign ack_seen     = res.ack_seen;

endmodule

>>> rtl/i2cbb_checker.sv
// ---------------------------------------------------------------------------
// i2cbb_checker
// port-level checks on the i2c bit engine, bound to the top level
// ---------------------------------------------------------------------------
module i2cbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       scl_level,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte
);

  // a finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done_res with busy_res");

  // input back-pressure only once a result is already waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without pending result");

  // after every accepted transaction a result is valid at the output next cycle
  a_accept_gives_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(read_byte))
    else $error("stalled result changed");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .scl_level (scl_level),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .read_byte (read_byte)
);
